### rtl/mwa_pkg.sv
// Shared constants, command and status types for the assignment solver.
package mwa_pkg;

    localparam int MAX_SIZE    = 16;
    localparam int IDX_W       = $clog2(MAX_SIZE);
    localparam int CNT_W       = IDX_W + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int POT_W       = WEIGHT_BITS + 2;
    localparam int SLK_W       = POT_W + 2;
    localparam int SIZE_W      = 5;

    localparam logic [CNT_W-1:0] UNMATCHED = CNT_W'(MAX_SIZE);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_START,
        OP_INIT_EV,
        OP_PH_START,
        OP_OUTER_SKIP,
        OP_CALL,
        OP_S1_EV,
        OP_MATCH_FREE,
        OP_S3_EV,
        OP_UNWIND,
        OP_UNWIND_DONE,
        OP_RET_OUTER,
        OP_POP,
        OP_RESUME,
        OP_PH_END,
        OP_MIN_START,
        OP_MIN_EV,
        OP_ADJ,
        OP_OUT_START,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic stack_row;
    } cmd_t;

    typedef struct packed {
        logic n_zero;
        logic scan_last;
        logic c_last;
        logic c_end;
        logic r_end;
        logic outer_skip;
        logic have_free;
        logic descend;
        logic sp_zero;
        logic sp_one;
        logic found_zero;
        logic will_finish;
        logic z_ok;
        logic out_free;
        logic out_last;
    } status_t;

endpackage

### rtl/mwa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/mwa_ctrl.sv
// Controller state machine sequencing load, search phases and result output.
module mwa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tlast,
    input  mwa_pkg::status_t st,
    output mwa_pkg::cmd_t    cmd,
    output logic             s_tready
);

    typedef enum logic [17:0] {
        ST_IDLE     = 18'h00001,
        ST_INIT_RD  = 18'h00002,
        ST_INIT_EV  = 18'h00004,
        ST_PH_START = 18'h00008,
        ST_OUTER    = 18'h00010,
        ST_S1_RD    = 18'h00020,
        ST_S1_EV    = 18'h00040,
        ST_S1_DONE  = 18'h00080,
        ST_S3_RD    = 18'h00100,
        ST_S3_EV    = 18'h00200,
        ST_UNWIND   = 18'h00400,
        ST_RET_F    = 18'h00800,
        ST_RESUME   = 18'h01000,
        ST_PH_END   = 18'h02000,
        ST_MIN_RD   = 18'h04000,
        ST_MIN_EV   = 18'h08000,
        ST_ADJ      = 18'h10000,
        ST_OUT      = 18'h20000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose next state and datapath command
    always_comb
    begin
        state_next    = state_reg;
        cmd.op        = mwa_pkg::OP_NONE;
        cmd.stack_row = 1'b0;
        s_tready      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tlast && !st.n_zero)
                begin
                    cmd.op     = mwa_pkg::OP_START;
                    state_next = ST_INIT_RD;
                end
            end
            ST_INIT_RD:
            begin
                state_next = ST_INIT_EV;
            end
            ST_INIT_EV:
            begin
                cmd.op     = mwa_pkg::OP_INIT_EV;
                state_next = st.scan_last ? ST_PH_START : ST_INIT_RD;
            end
            ST_PH_START:
            begin
                cmd.op     = mwa_pkg::OP_PH_START;
                state_next = ST_OUTER;
            end
            ST_OUTER:
            begin
                if (st.r_end)
                begin
                    state_next = ST_PH_END;
                end
                else if (st.outer_skip)
                begin
                    cmd.op = mwa_pkg::OP_OUTER_SKIP;
                end
                else
                begin
                    cmd.op     = mwa_pkg::OP_CALL;
                    state_next = ST_S1_RD;
                end
            end
            ST_S1_RD:
            begin
                cmd.stack_row = 1'b1;
                state_next    = ST_S1_EV;
            end
            ST_S1_EV:
            begin
                cmd.stack_row = 1'b1;
                cmd.op        = mwa_pkg::OP_S1_EV;
                state_next    = st.c_last ? ST_S1_DONE : ST_S1_RD;
            end
            ST_S1_DONE:
            begin
                cmd.stack_row = 1'b1;
                if (st.have_free)
                begin
                    cmd.op     = mwa_pkg::OP_MATCH_FREE;
                    state_next = ST_UNWIND;
                end
                else
                begin
                    state_next = ST_S3_RD;
                end
            end
            ST_S3_RD:
            begin
                cmd.stack_row = 1'b1;
                state_next    = st.c_end ? ST_RET_F : ST_S3_EV;
            end
            ST_S3_EV:
            begin
                cmd.stack_row = 1'b1;
                cmd.op        = mwa_pkg::OP_S3_EV;
                state_next    = st.descend ? ST_S1_RD : ST_S3_RD;
            end
            ST_UNWIND:
            begin
                if (st.sp_zero)
                begin
                    cmd.op     = mwa_pkg::OP_UNWIND_DONE;
                    state_next = ST_OUTER;
                end
                else
                begin
                    cmd.op = mwa_pkg::OP_UNWIND;
                end
            end
            ST_RET_F:
            begin
                if (st.sp_one)
                begin
                    cmd.op     = mwa_pkg::OP_RET_OUTER;
                    state_next = ST_OUTER;
                end
                else
                begin
                    cmd.op     = mwa_pkg::OP_POP;
                    state_next = ST_RESUME;
                end
            end
            ST_RESUME:
            begin
                cmd.op     = mwa_pkg::OP_RESUME;
                state_next = ST_S3_RD;
            end
            ST_PH_END:
            begin
                if (st.found_zero)
                begin
                    cmd.op     = mwa_pkg::OP_MIN_START;
                    state_next = ST_MIN_RD;
                end
                else
                begin
                    cmd.op     = mwa_pkg::OP_PH_END;
                    state_next = st.will_finish ? ST_OUT : ST_PH_START;
                end
            end
            ST_MIN_RD:
            begin
                state_next = ST_MIN_EV;
            end
            ST_MIN_EV:
            begin
                cmd.op     = mwa_pkg::OP_MIN_EV;
                state_next = st.scan_last ? ST_ADJ : ST_MIN_RD;
            end
            ST_ADJ:
            begin
                if (st.z_ok)
                begin
                    cmd.op     = mwa_pkg::OP_ADJ;
                    state_next = ST_PH_START;
                end
                else
                begin
                    cmd.op     = mwa_pkg::OP_OUT_START;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op = mwa_pkg::OP_EMIT;
                    if (st.out_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/mwa_dp.sv
// Datapath: weight store, potentials, matching, search stack and output register.
module mwa_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwa_pkg::cmd_t                       cmd,
    output mwa_pkg::status_t                    st,
    input  logic                                in_accept,
    input  logic [mwa_pkg::IDX_W-1:0]           in_row,
    input  logic [mwa_pkg::IDX_W-1:0]           in_col,
    input  logic [mwa_pkg::WEIGHT_BITS-1:0]     in_weight,
    input  logic                                cfg_we,
    input  logic [mwa_pkg::SIZE_W-1:0]          cfg_wdata,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [mwa_pkg::IDX_W-1:0]           out_row,
    output logic [mwa_pkg::IDX_W-1:0]           out_col,
    output logic                                out_last
);

    localparam int N = mwa_pkg::MAX_SIZE;
    localparam int IW = mwa_pkg::IDX_W;
    localparam int CW = mwa_pkg::CNT_W;
    localparam int PW = mwa_pkg::POT_W;
    localparam int SW = mwa_pkg::SLK_W;

    // Control registers
    logic [mwa_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [CW-1:0]              r_reg, r_next;
    logic [CW-1:0]              c_reg, c_next;
    logic [CW-1:0]              sp_reg, sp_next;
    logic [CW-1:0]              found_reg, found_next;
    logic [CW-1:0]              matched_reg, matched_next;
    logic                       hf_reg, hf_next;
    logic                       zv_reg, zv_next;
    logic [N-1:0]               rseen_reg, rseen_next;
    logic [N-1:0]               cseen_reg, cseen_next;
    logic                       mv_reg, mv_next;

    // Payload registers
    logic [IW-1:0]          free_reg, free_next;
    logic signed [SW-1:0]   z_reg, z_next;
    logic signed [PW-1:0]   rp_reg [N];
    logic signed [PW-1:0]   rp_next [N];
    logic signed [PW-1:0]   cp_reg [N];
    logic signed [PW-1:0]   cp_next [N];
    logic [CW-1:0]          rpart_reg [N];
    logic [CW-1:0]          rpart_next [N];
    logic [CW-1:0]          cpart_reg [N];
    logic [CW-1:0]          cpart_next [N];
    logic [IW-1:0]          stk_row_reg [N];
    logic [IW-1:0]          stk_row_next [N];
    logic [IW-1:0]          stk_col_reg [N];
    logic [IW-1:0]          stk_col_next [N];
    logic [IW-1:0]          orow_reg, orow_next;
    logic [IW-1:0]          ocol_reg, ocol_next;
    logic                   olast_reg, olast_next;

    // Combinational helpers
    logic [mwa_pkg::WEIGHT_BITS-1:0] rdata;
    logic [mwa_pkg::ADDR_W-1:0]      raddr;
    logic [CW-1:0]                   sp_m1;
    logic [IW-1:0]                   top_idx;
    logic [IW-1:0]                   top_row;
    logic [IW-1:0]                   top_col;
    logic [IW-1:0]                   row_sel;
    logic [IW-1:0]                   r4;
    logic [IW-1:0]                   c4;
    logic signed [PW-1:0]            rp_sel;
    logic signed [PW-1:0]            cp_sel;
    logic signed [SW-1:0]            slack;
    logic                            tight;
    logic [CW-1:0]                   cpart_c;
    logic                            col_free;
    logic [IW-1:0]                   child;
    logic                            descend;
    logic [CW-1:0]                   rpart_r;
    logic                            c_last;
    logic                            r_last;
    logic [CW-1:0]                   nsat;

    mwa_ram #(
        .WIDTH (mwa_pkg::WEIGHT_BITS),
        .DEPTH (N * N)
    ) u_wmem (
        .clk   (clk),
        .we    (in_accept),
        .waddr ({in_row, in_col}),
        .wdata (in_weight),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Look up stack top, entry slack and partner state
    always_comb
    begin
        sp_m1    = sp_reg - CW'(1);
        top_idx  = sp_m1[IW-1:0];
        top_row  = stk_row_reg[top_idx];
        top_col  = stk_col_reg[top_idx];
        r4       = r_reg[IW-1:0];
        c4       = c_reg[IW-1:0];
        row_sel  = cmd.stack_row ? top_row : r4;
        raddr    = {row_sel, c4};
        rp_sel   = rp_reg[row_sel];
        cp_sel   = cp_reg[c4];
        slack    = SW'(rp_sel) + SW'(cp_sel) - SW'({1'b0, rdata});
        tight    = (slack == '0);
        cpart_c  = cpart_reg[c4];
        col_free = (cpart_c == mwa_pkg::UNMATCHED);
        child    = cpart_c[IW-1:0];
        descend  = tight && !col_free && !rseen_reg[child];
        rpart_r  = rpart_reg[r4];
        c_last   = (c_reg == n_reg - CW'(1));
        r_last   = (r_reg == n_reg - CW'(1));
        nsat     = (size_reg > mwa_pkg::SIZE_W'(N)) ? CW'(N) : CW'(size_reg);
    end

    // Report status to the controller
    always_comb
    begin
        st.n_zero      = (size_reg == '0);
        st.scan_last   = r_last && c_last;
        st.c_last      = c_last;
        st.c_end       = (c_reg == n_reg);
        st.r_end       = (r_reg == n_reg);
        st.outer_skip  = (rpart_r != mwa_pkg::UNMATCHED) || rseen_reg[r4];
        st.have_free   = hf_reg;
        st.descend     = descend;
        st.sp_zero     = (sp_reg == '0);
        st.sp_one      = (sp_reg == CW'(1));
        st.found_zero  = (found_reg == '0);
        st.will_finish = ((matched_reg + found_reg) == n_reg);
        st.z_ok        = zv_reg && (z_reg > 0);
        st.out_free    = !mv_reg || out_ready;
        st.out_last    = r_last;
    end

    // Execute the command
    always_comb
    begin
        size_next    = cfg_we ? cfg_wdata : size_reg;
        n_next       = n_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        sp_next      = sp_reg;
        found_next   = found_reg;
        matched_next = matched_reg;
        hf_next      = hf_reg;
        zv_next      = zv_reg;
        rseen_next   = rseen_reg;
        cseen_next   = cseen_reg;
        free_next    = free_reg;
        z_next       = z_reg;
        rp_next      = rp_reg;
        cp_next      = cp_reg;
        rpart_next   = rpart_reg;
        cpart_next   = cpart_reg;
        stk_row_next = stk_row_reg;
        stk_col_next = stk_col_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        olast_next   = olast_reg;
        mv_next      = out_ready ? 1'b0 : mv_reg;
        case (cmd.op)
            mwa_pkg::OP_START:
            begin
                n_next       = nsat;
                r_next       = '0;
                c_next       = '0;
                matched_next = '0;
                for (int i = 0; i < N; i++)
                begin
                    rp_next[i]    = '0;
                    cp_next[i]    = '0;
                    rpart_next[i] = mwa_pkg::UNMATCHED;
                    cpart_next[i] = mwa_pkg::UNMATCHED;
                end
            end
            mwa_pkg::OP_INIT_EV:
            begin
                if ($signed({2'b00, rdata}) > rp_sel)
                begin
                    rp_next[r4] = $signed({2'b00, rdata});
                end
                c_next = c_last ? '0 : c_reg + CW'(1);
                r_next = c_last ? r_reg + CW'(1) : r_reg;
            end
            mwa_pkg::OP_PH_START:
            begin
                rseen_next = '0;
                cseen_next = '0;
                r_next     = '0;
                found_next = '0;
                sp_next    = '0;
            end
            mwa_pkg::OP_OUTER_SKIP:
            begin
                r_next = r_reg + CW'(1);
            end
            mwa_pkg::OP_CALL:
            begin
                stk_row_next[0] = r4;
                sp_next         = CW'(1);
                rseen_next[r4]  = 1'b1;
                c_next          = '0;
                hf_next         = 1'b0;
            end
            mwa_pkg::OP_S1_EV:
            begin
                if (tight)
                begin
                    cseen_next[c4] = 1'b1;
                    if (col_free && !hf_reg)
                    begin
                        free_next = c4;
                        hf_next   = 1'b1;
                    end
                end
                c_next = c_last ? '0 : c_reg + CW'(1);
            end
            mwa_pkg::OP_MATCH_FREE:
            begin
                rpart_next[top_row]  = {1'b0, free_reg};
                cpart_next[free_reg] = {1'b0, top_row};
                sp_next              = sp_m1;
            end
            mwa_pkg::OP_S3_EV:
            begin
                if (descend)
                begin
                    stk_col_next[top_idx]          = c4;
                    stk_row_next[sp_reg[IW-1:0]]   = child;
                    sp_next                        = sp_reg + CW'(1);
                    rseen_next[child]              = 1'b1;
                    c_next                         = '0;
                    hf_next                        = 1'b0;
                end
                else
                begin
                    c_next = c_reg + CW'(1);
                end
            end
            mwa_pkg::OP_UNWIND:
            begin
                rpart_next[top_row] = {1'b0, top_col};
                cpart_next[top_col] = {1'b0, top_row};
                sp_next             = sp_m1;
            end
            mwa_pkg::OP_UNWIND_DONE:
            begin
                found_next = found_reg + CW'(1);
                r_next     = r_reg + CW'(1);
            end
            mwa_pkg::OP_RET_OUTER:
            begin
                sp_next = '0;
                r_next  = r_reg + CW'(1);
            end
            mwa_pkg::OP_POP:
            begin
                sp_next = sp_m1;
            end
            mwa_pkg::OP_RESUME:
            begin
                c_next = {1'b0, top_col} + CW'(1);
            end
            mwa_pkg::OP_PH_END:
            begin
                matched_next = matched_reg + found_reg;
                r_next       = '0;
            end
            mwa_pkg::OP_MIN_START:
            begin
                r_next  = '0;
                c_next  = '0;
                zv_next = 1'b0;
            end
            mwa_pkg::OP_MIN_EV:
            begin
                if (rseen_reg[r4] && !cseen_reg[c4] && (!zv_reg || (slack < z_reg)))
                begin
                    z_next  = slack;
                    zv_next = 1'b1;
                end
                c_next = c_last ? '0 : c_reg + CW'(1);
                r_next = c_last ? r_reg + CW'(1) : r_reg;
            end
            mwa_pkg::OP_ADJ:
            begin
                for (int i = 0; i < N; i++)
                begin
                    if (rseen_reg[i])
                    begin
                        rp_next[i] = rp_reg[i] - PW'(z_reg);
                    end
                    if (cseen_reg[i])
                    begin
                        cp_next[i] = cp_reg[i] + PW'(z_reg);
                    end
                end
            end
            mwa_pkg::OP_OUT_START:
            begin
                r_next = '0;
            end
            mwa_pkg::OP_EMIT:
            begin
                orow_next  = r4;
                ocol_next  = (rpart_r < n_reg) ? rpart_r[IW-1:0] : '0;
                olast_next = r_last;
                mv_next    = 1'b1;
                r_next     = r_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg    <= mwa_pkg::SIZE_W'(N);
            n_reg       <= '0;
            r_reg       <= '0;
            c_reg       <= '0;
            sp_reg      <= '0;
            found_reg   <= '0;
            matched_reg <= '0;
            hf_reg      <= 1'b0;
            zv_reg      <= 1'b0;
            rseen_reg   <= '0;
            cseen_reg   <= '0;
            mv_reg      <= 1'b0;
        end
        else
        begin
            size_reg    <= size_next;
            n_reg       <= n_next;
            r_reg       <= r_next;
            c_reg       <= c_next;
            sp_reg      <= sp_next;
            found_reg   <= found_next;
            matched_reg <= matched_next;
            hf_reg      <= hf_next;
            zv_reg      <= zv_next;
            rseen_reg   <= rseen_next;
            cseen_reg   <= cseen_next;
            mv_reg      <= mv_next;
        end
    end

    // Hold payload state
    always_ff @(posedge clk)
    begin
        free_reg    <= free_next;
        z_reg       <= z_next;
        rp_reg      <= rp_next;
        cp_reg      <= cp_next;
        rpart_reg   <= rpart_next;
        cpart_reg   <= cpart_next;
        stk_row_reg <= stk_row_next;
        stk_col_reg <= stk_col_next;
        orow_reg    <= orow_next;
        ocol_reg    <= ocol_next;
        olast_reg   <= olast_next;
    end

    assign out_valid = mv_reg;
    assign out_row   = orow_reg;
    assign out_col   = ocol_reg;
    assign out_last  = olast_reg;

endmodule

### rtl/max_weight_assignment_solver_core.sv
// Loading: one weight item per cycle while idle; the item with tlast starts a solve if size is nonzero.
// Solve: a scan for row maxima, then search phases; a phase that finds no augmenting path is followed
// by a slack-minimum scan and a shift of the potentials, or ends the solve if no positive slack is left.
// Results: n items, one per cycle while m_tready is high, after the solve.
// The single read port of the weight memory sets the pace of every scan.
// Reset (rst_n low, asynchronous) empties the output and sets matrix size to 16.
module max_weight_assignment_solver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[3:0], col_index[7:4], weight[23:8]
    input  logic        s_tlast,   // last_entry
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // row_index_out[3:0], assigned_col[7:4]
    output logic        m_tlast,   // last_result
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata  // matrix_size
);

    mwa_pkg::cmd_t    cmd;
    mwa_pkg::status_t st;
    logic             in_accept;

    assign in_accept = s_tvalid && s_tready;

    mwa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .st       (st),
        .cmd      (cmd),
        .s_tready (s_tready)
    );

    mwa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_accept (in_accept),
        .in_row    (s_tdata[3:0]),
        .in_col    (s_tdata[7:4]),
        .in_weight (s_tdata[23:8]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_row   (m_tdata[3:0]),
        .out_col   (m_tdata[7:4]),
        .out_last  (m_tlast)
    );

endmodule

### rtl/mwa_checker.sv
// Port-level checks for the assignment solver, bound to the top level.
module mwa_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // Output is empty right after reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !m_tvalid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Take no input while a result run is still being sent
    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during result run");

    // Follow a taken non-final result with the next row
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
        m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0]) + 4'd1))
        else $error("result rows not consecutive");

    // Drain the output after the final result is taken
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result follows the final result");

endmodule

bind max_weight_assignment_solver_core mwa_checker u_mwa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### sim/max_weight_assignment_solver_checker.sv
// Checker for the assignment solver: predicts row assignments and compares them.
`timescale 1ns / 1ps

module max_weight_assignment_solver_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    output int          fail_count,
    output int          pending_rows
);

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic       last;
    } assign_t;

    logic [mwa_pkg::WEIGHT_BITS-1:0] weights [mwa_pkg::MAX_SIZE*mwa_pkg::MAX_SIZE];
    longint row_pot [mwa_pkg::MAX_SIZE];
    longint col_pot [mwa_pkg::MAX_SIZE];
    int     row_mate [mwa_pkg::MAX_SIZE];
    int     col_mate [mwa_pkg::MAX_SIZE];
    bit     row_vis [mwa_pkg::MAX_SIZE];
    bit     col_vis [mwa_pkg::MAX_SIZE];
    int     size_reg;
    int     n_used;
    assign_t assignments_due [$];

    function automatic longint slack(int r, int c);
        return row_pot[r] + col_pot[c] - longint'(weights[r*mwa_pkg::MAX_SIZE+c]);
    endfunction

    function automatic bit try_augment(int r);
        if (r >= n_used || row_vis[r])
            return 0;
        row_vis[r] = 1;
        for (int c = 0; c < n_used; c++)
            if (slack(r, c) == 0)
                col_vis[c] = 1;
        for (int c = 0; c < n_used; c++)
            if (slack(r, c) == 0 && col_mate[c] == mwa_pkg::MAX_SIZE)
            begin
                row_mate[r] = c;
                col_mate[c] = r;
                return 1;
            end
        for (int c = 0; c < n_used; c++)
            if (slack(r, c) == 0 && col_mate[c] != mwa_pkg::MAX_SIZE
                && try_augment(col_mate[c]))
            begin
                row_mate[r] = c;
                col_mate[c] = r;
                return 1;
            end
        return 0;
    endfunction

    // Run the Hungarian solve and queue one assignment per row.
    task automatic solve_assignment();
        int matched;
        int found;
        longint z;
        longint s;
        assign_t a;
        matched = 0;
        for (int i = 0; i < mwa_pkg::MAX_SIZE; i++)
        begin
            row_pot[i] = 0;
            col_pot[i] = 0;
            row_mate[i] = mwa_pkg::MAX_SIZE;
            col_mate[i] = mwa_pkg::MAX_SIZE;
        end
        for (int r = 0; r < n_used; r++)
            for (int c = 0; c < n_used; c++)
                if (longint'(weights[r*mwa_pkg::MAX_SIZE+c]) > row_pot[r])
                    row_pot[r] = weights[r*mwa_pkg::MAX_SIZE+c];
        while (matched < n_used)
        begin
            found = 0;
            for (int i = 0; i < mwa_pkg::MAX_SIZE; i++)
            begin
                row_vis[i] = 0;
                col_vis[i] = 0;
            end
            for (int r = 0; r < n_used; r++)
                if (row_mate[r] == mwa_pkg::MAX_SIZE && try_augment(r))
                    found++;
            matched += found;
            if (found == 0)
            begin
                z = -1;
                for (int r = 0; r < n_used; r++)
                    if (row_vis[r])
                        for (int c = 0; c < n_used; c++)
                            if (!col_vis[c])
                            begin
                                s = slack(r, c);
                                if (z < 0 || s < z)
                                    z = s;
                            end
                if (z <= 0)
                    break;
                for (int i = 0; i < n_used; i++)
                begin
                    if (row_vis[i])
                        row_pot[i] -= z;
                    if (col_vis[i])
                        col_pot[i] += z;
                end
            end
        end
        for (int i = 0; i < n_used; i++)
        begin
            a.row = i[3:0];
            a.col = (row_mate[i] < n_used) ? row_mate[i][3:0] : 4'd0;
            a.last = (i + 1 == n_used);
            assignments_due.push_back(a);
        end
    endtask

    // Track config, store weights, solve on last entry, and check each result.
    always @(posedge clk or negedge rst_n)
    begin
        assign_t got;
        assign_t want;
        if (!rst_n)
        begin
            size_reg = 16;
            fail_count = 0;
            assignments_due.delete();
            pending_rows = 0;
        end
        else
        begin
            if (cfg_we)
                size_reg = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got.row = m_tdata[3:0];
                got.col = m_tdata[7:4];
                got.last = m_tlast;
                if (assignments_due.size() == 0)
                begin
                    $error("unexpected result item row=%0d col=%0d", got.row, got.col);
                    fail_count++;
                end
                else
                begin
                    want = assignments_due.pop_front();
                    if (got.row !== want.row)
                    begin
                        $error("row_index_out expected %0d actual %0d", want.row, got.row);
                        fail_count++;
                    end
                    if (got.col !== want.col)
                    begin
                        $error("assigned_col expected %0d actual %0d", want.col, got.col);
                        fail_count++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last_result expected %0d actual %0d", want.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                weights[s_tdata[3:0]*mwa_pkg::MAX_SIZE + s_tdata[7:4]] = s_tdata[23:8];
                if (s_tlast)
                begin
                    n_used = size_reg > mwa_pkg::MAX_SIZE ? mwa_pkg::MAX_SIZE : size_reg;
                    if (n_used > 0)
                        solve_assignment();
                end
            end
            pending_rows = assignments_due.size();
        end
    end
endmodule

### sim/max_weight_assignment_solver_core_test.sv
// Testbench top for the assignment solver: stimulus, config phases and verdict.
`timescale 1ns / 1ps

module max_weight_assignment_solver_core_test;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;
    int          fail_count;
    int          pending_rows;
    int          cycle_count = 0;
    int          loaded_items;
    int          ready_wait;
    int          ready_draw;

    max_weight_assignment_solver_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    max_weight_assignment_solver_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_rows(pending_rows)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: draw a wait for every result item, then take it.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_wait <= $urandom_range(0, 6);
        end
        else if (m_tready)
        begin
            ready_draw = $urandom_range(0, 6);
            if (ready_draw != 0 || !m_tvalid)
            begin
                m_tready   <= 1'b0;
                ready_wait <= ready_draw;
            end
        end
        else if (m_tvalid)
        begin
            if (ready_wait == 0)
                m_tready <= 1'b1;
            else
                ready_wait <= ready_wait - 1;
        end
    end

    // Send one weight item, with a random gap before it.
    task automatic send_entry(input int r, input int c, input int w, input bit last);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tlast <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {w[15:0], c[3:0], r[3:0]};
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        loaded_items++;
        @(negedge clk);
    endtask

    // Drop the input, wait for the solve to drain, then write the size register.
    task automatic set_size(input int n);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(negedge clk);
        while (pending_rows != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= n[4:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Load every entry of an n by n matrix, then solve.
    task automatic load_matrix(input int n, input int wmax);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_entry(r, c, $urandom_range(0, wmax), (r == n-1) && (c == n-1));
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tlast = 0;
        cfg_we = 0;
        cfg_wdata = '0;
        loaded_items = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;

        // Directed: size one with extremes, then a tied and a max-weight 2x2.
        set_size(1);
        send_entry(0, 0, 16'hFFFF, 1);
        send_entry(0, 0, 0, 1);
        set_size(2);
        send_entry(0, 0, 5, 0);
        send_entry(0, 1, 5, 0);
        send_entry(1, 0, 5, 0);
        send_entry(1, 1, 5, 1);
        send_entry(0, 0, 0, 0);
        send_entry(0, 1, 16'hFFFF, 0);
        send_entry(1, 0, 16'hFFFF, 0);
        send_entry(1, 1, 0, 1);
        // Weights kept and solve rerun without reload; index beyond size stored but unused.
        send_entry(15, 15, 16'hAAAA, 1);
        // Size zero yields nothing.
        set_size(0);
        send_entry(3, 12, 16'h5555, 1);

        // Random: small matrices.
        while (loaded_items < 140)
        begin
            set_size($urandom_range(1, 5));
            load_matrix(checker_i.size_reg, ($urandom_range(0, 1) != 0) ? 65535 : 7);
        end

        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(negedge clk);
        while (pending_rows != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### filelist.f
rtl/mwa_pkg.sv
rtl/mwa_ram.sv
rtl/mwa_ctrl.sv
rtl/mwa_dp.sv
rtl/max_weight_assignment_solver_core.sv
rtl/mwa_checker.sv
sim/max_weight_assignment_solver_checker.sv
sim/max_weight_assignment_solver_core_test.sv
